// File: rtl/core/csle_pkg.sv
// ============================================================================
// csle_pkg: shared types and constants of the compact sequential list engine
// Field widths, operation codes, state encoding and the command and status
// groups exchanged between the controller and the datapath.
// ============================================================================
`default_nettype none

package csle_pkg;

    localparam int KIND_W = 2;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int SLOT_W = 6;

    // Capacity register value after reset.
    localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_POS  = 2'd0,
        KIND_INS_SORT = 2'd1,
        KIND_REM_POS  = 2'd2,
        KIND_REM_VAL  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PREP_R,
        S_SHR,
        S_PUT,
        S_PREP_L,
        S_SHL,
        S_PREP_S,
        S_SCAN,
        S_DROP,
        S_FIN
    } t_state;

    // Update applied to the working index.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO
    } t_idx_op;

    // Read address relative to the working index.
    typedef enum logic [2:0] {
        RD_0,
        RD_M1,
        RD_M2,
        RD_P1,
        RD_P2
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT,
        WR_VALUE
    } t_wr_sel;

    typedef struct packed {
        logic    ld_item;
        t_idx_op idx_op;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    slot_ld;
        logic    ok_set;
        logic    res_clr;
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  ins_ok;
        logic  rem_ok;
        logic  empty;
        logic  at_bound;
        logic  next_bound;
        logic  last;
        logic  next_last;
        logic  rd_less;
        logic  rd_eq;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/csle_ifs.sv
// ============================================================================
// csle_ifs: handshake channels of the compact sequential list engine
// Request words, result words and capacity register writes, each carried
// with valid and ready.
// ============================================================================
`default_nettype none

interface csle_in_if;
    import csle_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [VAL_W-1:0]  value;
    logic [LEN_W-1:0]         position;
    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface csle_out_if;
    import csle_pkg::*;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    modport source (output valid, output ok, output slot, output length, input ready);
    modport sink   (input valid, input ok, input slot, input length, output ready);
endinterface

interface csle_cfg_if;
    import csle_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/compact_sequential_list_engine_top.sv
// ============================================================================
// compact_sequential_list_engine_top: gap-free list of signed words
// Insert at position, sorted insert, remove at position and remove by value
// on a list held in an entry store with one read and one write port, one
// result word per request.
// ============================================================================
// Sequence: a taken request word is decoded and the first read is prepared;
//   the shift or scan pass then moves or scans one entry per cycle through
//   the read port, the new value is written or the last entry dropped, and
//   the result word enters the output register once that is free. A refused
//   request goes from decode straight to the state that loads the output.
// Throughput: one request at a time; the next request word is taken the
//   cycle after the result enters the output register, even while it waits.
// Reset: count clears, the capacity register returns to 64, the entry store
//   is not cleared and needs no clearing pass.
`default_nettype none

module compact_sequential_list_engine_top #(
    parameter int DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    csle_in_if.sink     i_in,
    csle_out_if.source  o_out,
    csle_cfg_if.sink    i_cfg
);
    import csle_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // The capacity register may be written at any time; the user writes it
    // only while the engine is idle.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // The sequencer owns all decisions; the datapath only follows commands
    // and reports compare results, the count checks and output availability.
    csle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // The datapath holds the entry store, the count, the working index and the
    // output register that decouples the result word from the request side.
    csle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_in.kind),
        .i_value     (i_in.value),
        .i_position  (i_in.position),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_ok        (o_out.ok),
        .o_slot      (o_out.slot),
        .o_length    (o_out.length)
    );

    // A refused request always reports slot zero.
    a_refused_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> (o_out.slot == '0))
        else $error("refused result carries a nonzero slot");

    // The store is never written while a new request word could be taken.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> !in_ready)
        else $error("store written while idle");

    // A taken request word blocks the request side in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    // The count never moves up and down at once.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("conflicting count update");

endmodule

`default_nettype wire

// File: rtl/core/csle_ctrl.sv
// ============================================================================
// csle_ctrl: operation sequencer
// Steps through decode, scan and shift passes and drives the datapath
// with one command word per cycle.
// ============================================================================
`default_nettype none

module csle_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire csle_pkg::t_stat  i_stat,
    output logic                  o_in_ready,
    output csle_pkg::t_cmd        o_cmd
);
    import csle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.kind) inside
                    KIND_INS_POS, KIND_INS_SORT: begin
                        n_state = i_stat.ins_ok ? S_PREP_R : S_FIN;
                    end
                    KIND_REM_POS: begin
                        n_state = i_stat.rem_ok ? S_PREP_L : S_FIN;
                    end
                    KIND_REM_VAL: begin
                        n_state = i_stat.empty ? S_FIN : S_PREP_S;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_PREP_R: begin
                n_state = i_stat.at_bound ? S_PUT : S_SHR;
            end
            S_SHR: begin
                if ((i_stat.kind == KIND_INS_SORT && i_stat.rd_less) || i_stat.next_bound) begin
                    n_state = S_PUT;
                end
            end
            S_PUT:    n_state = S_FIN;
            S_PREP_L: n_state = i_stat.last ? S_DROP : S_SHL;
            S_SHL: begin
                if (i_stat.next_last) n_state = S_DROP;
            end
            S_PREP_S: n_state = S_SCAN;
            S_SCAN: begin
                if (i_stat.rd_eq) begin
                    n_state = i_stat.last ? S_DROP : S_SHL;
                end else if (i_stat.last) begin
                    n_state = S_FIN;
                end
            end
            S_DROP:   n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Command word.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.ld_item  = i_in_valid;
            end
            S_DECODE: begin
                unique case (i_stat.kind) inside
                    KIND_INS_POS, KIND_INS_SORT: begin
                        if (i_stat.ins_ok) o_cmd.idx_op = IDX_COUNT;
                        else               o_cmd.res_clr = 1'b1;
                    end
                    KIND_REM_POS: begin
                        if (i_stat.rem_ok) o_cmd.idx_op = IDX_POS;
                        else               o_cmd.res_clr = 1'b1;
                    end
                    KIND_REM_VAL: begin
                        if (i_stat.empty) o_cmd.res_clr = 1'b1;
                        else              o_cmd.idx_op = IDX_ZERO;
                    end
                    default: o_cmd.res_clr = 1'b1;
                endcase
            end
            S_PREP_R: begin
                o_cmd.rd_sel = RD_M1;
            end
            S_SHR: begin
                if (!(i_stat.kind == KIND_INS_SORT && i_stat.rd_less)) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_SHIFT;
                    o_cmd.idx_op = IDX_DEC;
                    o_cmd.rd_sel = RD_M2;
                end
            end
            S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_VALUE;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.slot_ld = 1'b1;
                o_cmd.ok_set  = 1'b1;
            end
            S_PREP_L: begin
                o_cmd.slot_ld = 1'b1;
                o_cmd.rd_sel  = RD_P1;
            end
            S_SHL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.idx_op = IDX_INC;
                o_cmd.rd_sel = RD_P2;
            end
            S_PREP_S: begin
                o_cmd.rd_sel = RD_0;
            end
            S_SCAN: begin
                o_cmd.rd_sel = RD_P1;
                if (i_stat.rd_eq) begin
                    o_cmd.slot_ld = 1'b1;
                end else if (i_stat.last) begin
                    o_cmd.res_clr = 1'b1;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_DROP: begin
                o_cmd.cnt_dec = 1'b1;
                o_cmd.ok_set  = 1'b1;
            end
            S_FIN: begin
                o_cmd.out_ld = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/csle_dp.sv
// ============================================================================
// csle_dp: list datapath
// Entry store with one write and one registered read port, entry count,
// capacity register, working index, result and output registers.
// ============================================================================
`default_nettype none

module csle_dp #(
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire csle_pkg::t_cmd                 i_cmd,
    output csle_pkg::t_stat                     o_stat,
    input  wire logic [csle_pkg::KIND_W-1:0]    i_kind,
    input  wire logic signed [csle_pkg::VAL_W-1:0] i_value,
    input  wire logic [csle_pkg::LEN_W-1:0]     i_position,
    input  wire logic                           i_cfg_valid,
    input  wire logic [csle_pkg::LEN_W-1:0]     i_cfg_data,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_ok,
    output logic [csle_pkg::SLOT_W-1:0]         o_slot,
    output logic [csle_pkg::LEN_W-1:0]          o_length
);
    import csle_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic signed [VAL_W-1:0] mem [DEPTH];

    t_kind                   r_kind;
    logic signed [VAL_W-1:0] r_value;
    logic [LEN_W-1:0]        r_pos;
    logic [LEN_W-1:0]        r_idx;
    logic [LEN_W-1:0]        n_idx;
    logic [LEN_W-1:0]        r_count;
    logic [LEN_W-1:0]        r_cap;
    logic [LEN_W-1:0]        r_slot;
    logic                    r_ok;
    logic signed [VAL_W-1:0] r_rdata;
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [SLOT_W-1:0]       r_out_slot;
    logic [LEN_W-1:0]        r_out_len;

    logic [LEN_W-1:0]        rd_idx;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [LEN_W-1:0]        bound;
    logic [LEN_W:0]          idx_p1;
    logic [LEN_W:0]          idx_p2;
    logic [LEN_W:0]          cnt_ext;
    logic                    room;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_M1:   rd_idx = r_idx - 7'd1;
            RD_M2:   rd_idx = r_idx - 7'd2;
            RD_P1:   rd_idx = r_idx + 7'd1;
            RD_P2:   rd_idx = r_idx + 7'd2;
            default: rd_idx = r_idx;
        endcase
    end

    assign rd_addr = AW'(rd_idx);
    assign wr_addr = AW'(r_idx);
    assign wr_data = (i_cmd.wr_sel == WR_VALUE) ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_INC:   n_idx = r_idx + 7'd1;
            IDX_DEC:   n_idx = r_idx - 7'd1;
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = r_pos;
            IDX_ZERO:  n_idx = '0;
            default:   n_idx = r_idx;
        endcase
    end

    // Operand, index and result registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
            r_pos   <= i_position;
        end
        r_idx <= n_idx;
        if (i_cmd.res_clr) begin
            r_slot <= '0;
            r_ok   <= 1'b0;
        end else begin
            if (i_cmd.slot_ld) r_slot <= r_idx;
            if (i_cmd.ok_set)  r_ok   <= 1'b1;
        end
        if (i_cmd.out_ld) begin
            r_out_ok   <= r_ok;
            r_out_slot <= r_slot[SLOT_W-1:0];
            r_out_len  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc)      r_count <= r_count + 7'd1;
            else if (i_cmd.cnt_dec) r_count <= r_count - 7'd1;
            if (i_cfg_valid) r_cap <= i_cfg_data;
            if (i_cmd.out_ld)     r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign bound   = (r_kind == KIND_INS_POS) ? r_pos : '0;
    assign idx_p1  = {1'b0, r_idx} + 8'd1;
    assign idx_p2  = {1'b0, r_idx} + 8'd2;
    assign cnt_ext = {1'b0, r_count};
    assign room    = (r_count < r_cap) && (32'(r_count) < DEPTH);

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.ins_ok     = room && ((r_kind != KIND_INS_POS) || (r_pos <= r_count));
        o_stat.rem_ok     = r_pos < r_count;
        o_stat.empty      = r_count == '0;
        o_stat.at_bound   = r_idx == bound;
        o_stat.next_bound = (r_idx - 7'd1) == bound;
        o_stat.last       = idx_p1 >= cnt_ext;
        o_stat.next_last  = idx_p2 >= cnt_ext;
        o_stat.rd_less    = r_rdata < r_value;
        o_stat.rd_eq      = r_rdata == r_value;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_slot      = r_out_slot;
    assign o_length    = r_out_len;

endmodule

`default_nettype wire
